// File: design/tun_pkg.sv
// Package for the triangle unit normal block: default widths shared by
// the interfaces and the top level. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package tun_pkg;
	// Default coordinate width and fraction bits of the normal.
	localparam int unsigned COORD_WIDTH_DEF = 16;
	localparam int unsigned FRAC_BITS_DEF   = 15;
endpackage
`default_nettype wire

// File: design/tun_if.sv
// Channel interfaces of the triangle unit normal block: triangle in, normal out.
// Depends on tun_pkg for default widths.
`timescale 1ns / 1ps
`default_nettype none
interface tun_in_if #(
	parameter int unsigned COORD_WIDTH = tun_pkg::COORD_WIDTH_DEF
);
	logic valid;
	logic ready;
	logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
	modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
	modport sink (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tun_out_if #(
	parameter int unsigned NORMAL_FRAC_BITS = tun_pkg::FRAC_BITS_DEF
);
	logic valid;
	logic ready;
	logic signed [NORMAL_FRAC_BITS:0] normal_x, normal_y, normal_z;
	logic degenerate;
	modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface
`default_nettype wire

// File: design/tun_front.sv
// Front end: edge vectors, cross product, squared components and their sum.
// Five register stages; depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none
module tun_front #(
	parameter int unsigned CW  = 16,
	parameter int unsigned MW  = 2 * CW + 2,
	parameter int unsigned SQW = 2 * MW,
	parameter int unsigned SW  = SQW + 2
) (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz,
	output logic         [SW-1:0]     sum_s5,
	output logic         [SQW-1:0]    sq_s5 [3],
	output logic                      neg_s5 [3]
);
	localparam int unsigned EW = CW + 1;
	localparam int unsigned PW = 2 * EW;
	localparam int unsigned NW = PW + 1;

	logic signed [EW-1:0] u_s1 [3];
	logic signed [EW-1:0] v_s1 [3];
	logic signed [PW-1:0] p_s2 [6];
	logic signed [NW-1:0] n_s3 [3];
	logic        [SQW-1:0] sq_s4 [3];
	logic                  neg_s4 [3];
	logic        [MW-1:0]  mag [3];

	// Stage 1: edges b - a and c - a.
	always_ff @(posedge clk) begin
		if (en) begin
			u_s1[0] <= EW'(bx) - EW'(ax);
			u_s1[1] <= EW'(by) - EW'(ay);
			u_s1[2] <= EW'(bz) - EW'(az);
			v_s1[0] <= EW'(cx) - EW'(ax);
			v_s1[1] <= EW'(cy) - EW'(ay);
			v_s1[2] <= EW'(cz) - EW'(az);
		end
	end

	// Stage 2: the six partial products of the cross product.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= u_s1[1] * v_s1[2];
			p_s2[1] <= u_s1[2] * v_s1[1];
			p_s2[2] <= u_s1[2] * v_s1[0];
			p_s2[3] <= u_s1[0] * v_s1[2];
			p_s2[4] <= u_s1[0] * v_s1[1];
			p_s2[5] <= u_s1[1] * v_s1[0];
		end
	end

	// Stage 3: cross product components.
	always_ff @(posedge clk) begin
		if (en) begin
			n_s3[0] <= NW'(p_s2[0]) - NW'(p_s2[1]);
			n_s3[1] <= NW'(p_s2[2]) - NW'(p_s2[3]);
			n_s3[2] <= NW'(p_s2[4]) - NW'(p_s2[5]);
		end
	end

	// Stage 4: magnitudes squared, signs kept aside.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = n_s3[i][NW-1] ? MW'(-n_s3[i]) : MW'(n_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s4[i]  <= mag[i] * mag[i];
				neg_s4[i] <= n_s3[i][NW-1];
			end
		end
	end

	// Stage 5: squared length.
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s5 <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]);
			for (int i = 0; i < 3; i++) begin
				sq_s5[i]  <= sq_s4[i];
				neg_s5[i] <= neg_s4[i];
			end
		end
	end
endmodule
`default_nettype wire

// File: design/tun_lane.sv
// One component lane: finds the rounded quotient one bit per stage.
// Uses only shifts and adds; depends on nothing beyond its parameters.
`timescale 1ns / 1ps
`default_nettype none
module tun_lane #(
	parameter int unsigned F   = 15,
	parameter int unsigned SQW = 68,
	parameter int unsigned SW  = SQW + 2
) (
	input  wire logic           clk,
	input  wire logic           en,
	input  wire logic [SW-1:0]  sum_in,
	input  wire logic [SQW-1:0] sq_in,
	input  wire logic           neg_in,
	output logic      [F:0]     quot,
	output logic                neg
);
	localparam int unsigned DW = F + 3;
	localparam int unsigned WW = SW + 2 * DW + 2;

	// With d = 2q - 1, each stage keeps a = d*S and b = d*d*S, and tries
	// to set one more bit of q while b stays within t = 4*n*n*2^(2F).
	logic signed [WW-1:0] a_s [F+1];
	logic signed [WW-1:0] b_s [F+1];
	logic signed [WW-1:0] t_s [F+1];
	logic        [SW-1:0] s_s [F+1];
	logic        [F:0]    q_s [F+1];
	logic                 n_s [F+1];

	for (genvar gi = 0; gi <= F; gi++) begin : g_bit
		localparam int unsigned K = F - gi;
		logic signed [WW-1:0] a_in, b_in, t_in, s_w, a_try, b_try;
		logic        [SW-1:0] s_in;
		logic        [F:0]    q_in;
		logic                 n_in;
		logic                 fits;

		if (gi == 0) begin : g_first
			assign s_in = sum_in;
			assign a_in = -$signed({{(WW-SW){1'b0}}, sum_in});
			assign b_in = $signed({{(WW-SW){1'b0}}, sum_in});
			assign t_in = $signed({{(WW-SQW){1'b0}}, sq_in}) <<< (2 * F + 2);
			assign q_in = '0;
			assign n_in = neg_in;
		end else begin : g_next
			assign s_in = s_s[gi-1];
			assign a_in = a_s[gi-1];
			assign b_in = b_s[gi-1];
			assign t_in = t_s[gi-1];
			assign q_in = q_s[gi-1];
			assign n_in = n_s[gi-1];
		end

		// Trial with bit K of q set.
		assign s_w   = $signed({{(WW-SW){1'b0}}, s_in});
		assign a_try = a_in + (s_w <<< (K + 1));
		assign b_try = b_in + (a_in <<< (K + 2)) + (s_w <<< (2 * K + 2));
		assign fits  = (b_try <= t_in);

		always_ff @(posedge clk) begin
			if (en) begin
				s_s[gi] <= s_in;
				t_s[gi] <= t_in;
				n_s[gi] <= n_in;
				a_s[gi] <= fits ? a_try : a_in;
				b_s[gi] <= fits ? b_try : b_in;
				q_s[gi] <= fits ? (q_in | ((F+1)'(1) << K)) : q_in;
			end
		end
	end

	assign quot = q_s[F];
	assign neg  = n_s[F];
endmodule
`default_nettype wire

// File: design/triangle_unit_normal.sv
// Top level of the triangle unit normal block.
// Depends on tun_pkg, tun_if, tun_front and tun_lane.
//
// Takes one triangle per cycle and gives its unit face normal in signed
// fixed point with NORMAL_FRAC_BITS fraction bits, rounded to nearest (ties
// away from zero) and saturated; a zero cross product gives a zero normal with
// degenerate set. The pipeline has five stages for the edges, cross product and
// squared length, one stage per quotient bit in each component lane, and the
// output register. Throughput is one triangle per cycle; when the output is
// stalled the whole pipeline holds.
`timescale 1ns / 1ps
`default_nettype none
module triangle_unit_normal #(
	parameter int unsigned COORD_WIDTH      = tun_pkg::COORD_WIDTH_DEF,
	parameter int unsigned NORMAL_FRAC_BITS = tun_pkg::FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	tun_in_if.sink    tri_in,
	tun_out_if.source nrm_out
);
	import tun_pkg::*;

	localparam int unsigned F   = NORMAL_FRAC_BITS;
	localparam int unsigned MW  = 2 * COORD_WIDTH + 2;
	localparam int unsigned SQW = 2 * MW;
	localparam int unsigned SW  = SQW + 2;
	localparam int unsigned LAT = 5 + F + 1;

	logic              advance;
	logic [LAT-1:0]    vld_q;
	logic              out_vld_q;
	logic [SW-1:0]     sum_s5;
	logic [SQW-1:0]    sq_s5 [3];
	logic              neg_s5 [3];
	logic [F:0]        quot [3];
	logic              qneg [3];
	logic [F:0]        deg_q;
	logic signed [F:0] comp [3];

	// The pipeline moves whenever the output register is free or drained.
	assign advance      = !out_vld_q || nrm_out.ready;
	assign tri_in.ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (advance) begin
			vld_q     <= {vld_q[LAT-2:0], tri_in.valid};
			out_vld_q <= vld_q[LAT-1];
		end
	end

	tun_front #(.CW(COORD_WIDTH), .MW(MW), .SQW(SQW), .SW(SW)) u_front (
		.clk(clk), .en(advance),
		.ax(tri_in.ax), .ay(tri_in.ay), .az(tri_in.az),
		.bx(tri_in.bx), .by(tri_in.by), .bz(tri_in.bz),
		.cx(tri_in.cx), .cy(tri_in.cy), .cz(tri_in.cz),
		.sum_s5(sum_s5), .sq_s5(sq_s5), .neg_s5(neg_s5)
	);

	for (genvar li = 0; li < 3; li++) begin : g_lane
		tun_lane #(.F(F), .SQW(SQW), .SW(SW)) u_lane (
			.clk(clk), .en(advance),
			.sum_in(sum_s5), .sq_in(sq_s5[li]), .neg_in(neg_s5[li]),
			.quot(quot[li]), .neg(qneg[li])
		);
	end

	// Degenerate flag travels alongside the lanes.
	always_ff @(posedge clk) begin
		if (advance) begin
			deg_q <= {deg_q[F-1:0], (sum_s5 == '0)};
		end
	end

	// Sign and saturation of each component.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (qneg[i]) begin
				comp[i] = -$signed(quot[i]);
			end else if (quot[i][F]) begin
				comp[i] = $signed({1'b0, {F{1'b1}}});
			end else begin
				comp[i] = $signed(quot[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			nrm_out.degenerate <= deg_q[F];
			nrm_out.normal_x   <= deg_q[F] ? '0 : comp[0];
			nrm_out.normal_y   <= deg_q[F] ? '0 : comp[1];
			nrm_out.normal_z   <= deg_q[F] ? '0 : comp[2];
		end
	end

	assign nrm_out.valid = out_vld_q;
endmodule
`default_nettype wire

// File: design/tun_checker.sv
// Port-level checks for the triangle unit normal block, bound to the top level.
// Depends on tun_pkg and on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module tun_checker #(
	parameter int unsigned F = tun_pkg::FRAC_BITS_DEF
) (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         out_valid,
	input wire logic         out_ready,
	input wire logic [F:0]   nx,
	input wire logic [F:0]   ny,
	input wire logic [F:0]   nz,
	input wire logic         degenerate
);
	// A degenerate result carries a zero normal.
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> (nx == '0 && ny == '0 && nz == '0))
		else $error("degenerate result with a non-zero normal");

	// A proper triangle never gives an all-zero normal.
	a_nondeg_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !degenerate) |-> (nx != '0 || ny != '0 || nz != '0))
		else $error("non-degenerate result with a zero normal");

	// A stalled result stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result withdrawn before its transfer");

	// A stalled result keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(nx) && $stable(ny) && $stable(nz)
			&& $stable(degenerate)))
		else $error("result changed before its transfer");
endmodule

bind triangle_unit_normal tun_checker #(.F(NORMAL_FRAC_BITS)) u_tun_checker (
	.clk(clk), .arst_n(arst_n),
	.out_valid(nrm_out.valid), .out_ready(nrm_out.ready),
	.nx(nrm_out.normal_x), .ny(nrm_out.normal_y), .nz(nrm_out.normal_z),
	.degenerate(nrm_out.degenerate)
);
`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for triangle_unit_normal: drives triangles in, checks
// every unit normal against an exact integer predictor of the face normal.
// Depends on tun_pkg, tun_if and the triangle_unit_normal design files.
`timescale 1ns / 1ps
module testbench;
	import tun_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int PIPE_DEPTH = FB + 7;

	typedef struct packed {
		logic signed [CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
	} triangle_t;

	typedef struct packed {
		logic signed [FB:0] nx, ny, nz;
		logic degen;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tun_in_if #(.COORD_WIDTH(CW)) tri_ch();
	tun_out_if #(.NORMAL_FRAC_BITS(FB)) nrm_ch();

	triangle_unit_normal #(.COORD_WIDTH(CW), .NORMAL_FRAC_BITS(FB)) DUT (
		.clk(clk), .arst_n(arst_n), .tri_in(tri_ch.sink), .nrm_out(nrm_ch.source)
	);

	triangle_t pending_tris[$];
	normal_t expected_normals[$];
	int errors = 0;
	int sent = 0;
	int received = 0;
	int degen_seen = 0;
	int cycle = 0;

	always #4 clk = ~clk;

	// Rounded, saturated fixed-point quotient of one component by the length.
	function automatic logic [FB:0] unit_component(longint n, logic [127:0] len_sq);
		logic [127:0] m, lhs, rhs;
		longint lo, hi, mid, d;
		m = (n < 0) ? -n : n;
		rhs = (m * m) << (2 * FB + 2);
		lo = 0;
		hi = longint'(1) << FB;
		while (lo < hi) begin
			mid = (lo + hi + 1) >> 1;
			d = 2 * mid - 1;
			lhs = 128'(d * d) * len_sq;
			if (lhs <= rhs) lo = mid;
			else hi = mid - 1;
		end
		if (n < 0) return -lo[FB:0];
		if (lo >= (longint'(1) << FB)) return {1'b0, {FB{1'b1}}};
		return lo[FB:0];
	endfunction

	// Face normal of one triangle, exactly as the block should give it.
	function automatic normal_t face_normal(triangle_t t);
		longint ux, uy, uz, vx, vy, vz, nx, ny, nz;
		logic [127:0] len_sq;
		normal_t r;
		ux = longint'(t.bx) - longint'(t.ax);
		uy = longint'(t.by) - longint'(t.ay);
		uz = longint'(t.bz) - longint'(t.az);
		vx = longint'(t.cx) - longint'(t.ax);
		vy = longint'(t.cy) - longint'(t.ay);
		vz = longint'(t.cz) - longint'(t.az);
		nx = uy * vz - uz * vy;
		ny = uz * vx - ux * vz;
		nz = ux * vy - uy * vx;
		// The squares need more than 64 bits, so they are formed at full width.
		len_sq = 128'(nx) * 128'(nx) + 128'(ny) * 128'(ny) + 128'(nz) * 128'(nz);
		if (len_sq == 0) begin
			r = '{nx: '0, ny: '0, nz: '0, degen: 1'b1};
		end else begin
			r.nx = unit_component(nx, len_sq);
			r.ny = unit_component(ny, len_sq);
			r.nz = unit_component(nz, len_sq);
			r.degen = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch on result %0d: %s got %0d expected %0d", received, what, got, want);
	endtask

	// Appends one triangle to the queue of pending transfers.
	task automatic queue_tri(triangle_t t);
		pending_tris = {pending_tris, t};
	endtask

	// Idling is switched off for a long stretch in the middle of the run.
	function automatic bit take_break();
		if (cycle > 300 && cycle < 800) return 1'b0;
		return $urandom_range(99) < 23;
	endfunction

	// Driver: a transfer pops the triangle and records its expected normal.
	always @(posedge clk or negedge arst_n) begin
		automatic bit nxt_valid;
		automatic triangle_t nxt;
		if (!arst_n) begin
			tri_ch.valid <= 1'b0;
			{tri_ch.ax, tri_ch.ay, tri_ch.az, tri_ch.bx, tri_ch.by, tri_ch.bz,
				tri_ch.cx, tri_ch.cy, tri_ch.cz} <= '0;
		end else begin
			cycle++;
			if (tri_ch.valid && tri_ch.ready) begin
				expected_normals = {expected_normals, face_normal(pending_tris.pop_front())};
				sent++;
			end
			if (tri_ch.valid && !tri_ch.ready) begin
				nxt_valid = 1'b1;
			end else begin
				nxt_valid = pending_tris.size() > 0 && !take_break();
			end
			if (nxt_valid) begin
				nxt = pending_tris[0];
				{tri_ch.ax, tri_ch.ay, tri_ch.az, tri_ch.bx, tri_ch.by, tri_ch.bz,
					tri_ch.cx, tri_ch.cy, tri_ch.cz} <= nxt;
			end
			tri_ch.valid <= nxt_valid;
		end
	end

	// Monitor: each result transfer is checked against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		automatic normal_t want;
		if (!arst_n) begin
			nrm_ch.ready <= 1'b0;
		end else begin
			if (nrm_ch.valid && nrm_ch.ready) begin
				if (expected_normals.size() == 0) begin
					errors++;
					$display("result with no triangle outstanding");
				end else begin
					want = expected_normals.pop_front();
					if (nrm_ch.normal_x !== want.nx) report_mismatch("normal_x", nrm_ch.normal_x, want.nx);
					if (nrm_ch.normal_y !== want.ny) report_mismatch("normal_y", nrm_ch.normal_y, want.ny);
					if (nrm_ch.normal_z !== want.nz) report_mismatch("normal_z", nrm_ch.normal_z, want.nz);
					if (nrm_ch.degenerate !== want.degen)
						report_mismatch("degenerate", nrm_ch.degenerate, want.degen);
					if (want.degen) degen_seen++;
				end
				received++;
			end
			nrm_ch.ready <= !take_break();
		end
	end

	function automatic triangle_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
		int cx, int cy, int cz);
		triangle_t t;
		t = '{CW'(ax), CW'(ay), CW'(az), CW'(bx), CW'(by), CW'(bz), CW'(cx), CW'(cy), CW'(cz)};
		return t;
	endfunction

	function automatic logic [CW-1:0] rnd_coord();
		return CW'($urandom);
	endfunction

	// Stimulus: directed triangles, a pause until they drain, then random ones.
	initial begin
		automatic triangle_t t;
		automatic int kind, k;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Degenerate cases: all vertices equal, repeated vertex, collinear.
		queue_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
		queue_tri(make_tri(5, -7, 9, 5, -7, 9, 100, 3, -2));
		queue_tri(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
		queue_tri(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
			-32768, -32768, -32768));
		// Axis-aligned normals: full scale saturates, minus full scale fits.
		queue_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
		queue_tri(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
		queue_tri(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1));
		queue_tri(make_tri(0, 0, 0, 0, 0, 1, 0, 1, 0));
		queue_tri(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
		queue_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 0, 1));
		// Diagonal, extreme-coordinate and small triangles.
		queue_tri(make_tri(1, 0, 0, 0, 1, 0, 0, 0, 1));
		queue_tri(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
			-32768, 32767, -32768));
		queue_tri(make_tri(32767, 32767, 32767, -32768, 32767, -32768,
			32767, -32768, -32768));
		queue_tri(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
			-32768, -32768, 32767));
		queue_tri(make_tri(32767, -32768, 0, -32768, 32767, 1, 0, 0, 32767));
		queue_tri(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, 0));
		queue_tri(make_tri(0, 0, 0, 3, 4, 0, 1, 1, 0));
		queue_tri(make_tri(7, 7, 7, 8, 9, 7, 7, 7, 6));

		// Hold the sender until every directed result has come back.
		wait (pending_tris.size() == 0 && expected_normals.size() == 0);
		@(posedge clk);

		repeat (950) begin
			kind = $urandom_range(99);
			if (kind < 50) begin
				t = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
					rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
			end else if (kind < 80) begin
				// Small triangle around a random origin.
				t.ax = rnd_coord(); t.ay = rnd_coord(); t.az = rnd_coord();
				t.bx = t.ax + CW'($urandom_range(8) - 4);
				t.by = t.ay + CW'($urandom_range(8) - 4);
				t.bz = t.az + CW'($urandom_range(8) - 4);
				t.cx = t.ax + CW'($urandom_range(8) - 4);
				t.cy = t.ay + CW'($urandom_range(8) - 4);
				t.cz = t.az + CW'($urandom_range(8) - 4);
			end else if (kind < 90) begin
				// Collinear: c = a + k*(b - a).
				k = $urandom_range(4) - 2;
				t.ax = CW'($urandom_range(2000) - 1000);
				t.ay = CW'($urandom_range(2000) - 1000);
				t.az = CW'($urandom_range(2000) - 1000);
				t.bx = t.ax + CW'($urandom_range(200) - 100);
				t.by = t.ay + CW'($urandom_range(200) - 100);
				t.bz = t.az + CW'($urandom_range(200) - 100);
				t.cx = t.ax + CW'(k * (t.bx - t.ax));
				t.cy = t.ay + CW'(k * (t.by - t.ay));
				t.cz = t.az + CW'(k * (t.bz - t.az));
			end else begin
				// Random coordinates with ax, by and cz forced to extremes.
				t = {rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
					rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()};
				t.ax[CW-2:0] = {(CW-1){~t.ax[CW-1]}};
				t.by[CW-2:0] = {(CW-1){~t.by[CW-1]}};
				t.cz[CW-2:0] = {(CW-1){~t.cz[CW-1]}};
			end
			queue_tri(t);
		end

		wait (pending_tris.size() == 0 && expected_normals.size() == 0);
		repeat (PIPE_DEPTH * 2) @(posedge clk);
		if (expected_normals.size() != 0) errors++;
		$display("Covered %0d triangles and %0d normals, %0d of them degenerate,", sent,
			received, degen_seen);
		$display("with directed axis, extreme and collinear cases and random stalls.");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end
endmodule
